// File: hdl/alignment_window_variation_core_defines.svh
// Assertion macros shared by the alignment window variation core.
`ifndef ALIGNMENT_WINDOW_VARIATION_CORE_DEFINES_SVH
`define ALIGNMENT_WINDOW_VARIATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during rst.
`define AWVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst.
`define AWVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/awvc_pkg.sv
// Shared constants and types of the alignment window variation core.
`default_nettype none

package awvc_pkg;

  localparam int NUM_SEQUENCES_DEF     = 17;
  localparam int STEP_COLUMNS_DEF      = 100;
  localparam int WINDOW_BLOCKS_DEF     = 10;
  localparam int COLUMN_INDEX_BITS_DEF = 20;

  localparam int CODE_W    = 3;
  localparam int NUM_CODES = 5;
  localparam logic [CODE_W-1:0] CODE_GAP = 3'd4;

  localparam int COUNT_W   = 5;
  localparam int COL_VAR_W = 2;

  localparam int START_W = 20;
  localparam int GAP_W   = 15;
  localparam int VAR_W   = 12;
  localparam int TOTAL_W = 22;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COUNT_W-1:0]   gaps;
    logic [COL_VAR_W-1:0] vars;
    logic                 last;
  } col_sum_t;

endpackage

`default_nettype wire

// File: hdl/awvc_front.sv
// Column front end: code counting, consensus vote and per-column variant count.
`default_nettype none

module awvc_front #(
  parameter int NUM_SEQUENCES = awvc_pkg::NUM_SEQUENCES_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        column_valid,
  output logic                                             column_ready,
  input  wire logic [awvc_pkg::CODE_W*NUM_SEQUENCES-1:0]   column_bases,
  input  wire logic                                        last_column,
  output logic                                             sum_valid,
  input  wire logic                                        sum_ready,
  output awvc_pkg::col_sum_t                               sum
);

  logic [awvc_pkg::NUM_CODES-1:0][NUM_SEQUENCES-1:0] hit;
  logic [awvc_pkg::COUNT_W-1:0] count_comb [awvc_pkg::NUM_CODES];
  logic [awvc_pkg::COUNT_W-1:0] counts [awvc_pkg::NUM_CODES];
  logic                         stage_valid;
  logic                         stage_last;
  logic [awvc_pkg::CODE_W-1:0]  best;
  logic [awvc_pkg::COL_VAR_W-1:0] var_sum;

  always_comb begin
    for (int k = 0; k < awvc_pkg::NUM_CODES; k++) begin
      for (int j = 0; j < NUM_SEQUENCES; j++) begin
        hit[k][j] = (column_bases[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] ==
                     awvc_pkg::CODE_W'(k));
      end
      count_comb[k] = awvc_pkg::COUNT_W'($countones(hit[k]));
    end
  end

  assign column_ready = !stage_valid || sum_ready;
  assign sum_valid    = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (column_ready) begin
      stage_valid <= column_valid;
    end
    if (column_ready && column_valid) begin
      counts     <= count_comb;
      stage_last <= last_column;
    end
  end

  // vote with tie priority A, C, G, T, gap
  always_comb begin
    best = '0;
    for (int k = 1; k < awvc_pkg::NUM_CODES; k++) begin
      if (counts[k] > counts[best]) best = awvc_pkg::CODE_W'(k);
    end
    var_sum = '0;
    if (best != awvc_pkg::CODE_GAP) begin
      for (int k = 0; k < awvc_pkg::NUM_CODES - 1; k++) begin
        if ((awvc_pkg::CODE_W'(k) != best) && (counts[k] != '0)) begin
          var_sum = var_sum + awvc_pkg::COL_VAR_W'(1);
        end
      end
    end
  end

  assign sum.gaps = counts[awvc_pkg::CODE_GAP];
  assign sum.vars = var_sum;
  assign sum.last = stage_last;

endmodule

`default_nettype wire

// File: hdl/awvc_fifo.sv
// Small register queue between the column front end and the window back end.
`default_nettype none

module awvc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = awvc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/awvc_back.sv
// Window back end: block ring, running total and window result sequencer.
`default_nettype none

module awvc_back #(
  parameter int STEP_COLUMNS      = awvc_pkg::STEP_COLUMNS_DEF,
  parameter int WINDOW_BLOCKS     = awvc_pkg::WINDOW_BLOCKS_DEF,
  parameter int COLUMN_INDEX_BITS = awvc_pkg::COLUMN_INDEX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sum_valid,
  output logic                              sum_ready,
  input  wire awvc_pkg::col_sum_t           sum,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [awvc_pkg::START_W-1:0]      window_start,
  output logic [awvc_pkg::GAP_W-1:0]        gap_count,
  output logic [awvc_pkg::VAR_W-1:0]        variant_count,
  output logic [awvc_pkg::TOTAL_W-1:0]      total_variants,
  output logic                              last_of_run
);

  localparam int OFF_W  = (STEP_COLUMNS > 1) ? $clog2(STEP_COLUMNS) : 1;
  localparam int SLOT_W = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(WINDOW_BLOCKS + 1);
  localparam int CIB    = COLUMN_INDEX_BITS;
  localparam logic [CIB-1:0]    STEP_INC = CIB'(STEP_COLUMNS);
  localparam logic [OFF_W-1:0]  OFF_LAST = OFF_W'(STEP_COLUMNS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_BLOCKS - 1);
  localparam logic [CNT_W-1:0]  BLOCKS_FULL = CNT_W'(WINDOW_BLOCKS);

  typedef enum logic [1:0] {ST_IDLE, ST_GATHER, ST_EMIT} state_t;

  state_t                         state;
  logic [CIB-1:0]                 col;
  logic [OFF_W-1:0]               off;
  logic [SLOT_W-1:0]              slot;
  logic [CIB-1:0]                 blk_start;
  logic [CNT_W-1:0]               seen;
  logic [awvc_pkg::GAP_W-1:0]     cur_gap;
  logic [awvc_pkg::VAR_W-1:0]     cur_var;
  logic [awvc_pkg::TOTAL_W-1:0]   running_total;
  logic [awvc_pkg::GAP_W-1:0]     ring_gap [WINDOW_BLOCKS];
  logic [awvc_pkg::VAR_W-1:0]     ring_var [WINDOW_BLOCKS];
  logic [SLOT_W-1:0]              rd_slot;
  logic [CIB-1:0]                 rd_start;
  logic [CNT_W-1:0]               cnt;
  logic [CNT_W-1:0]               rem;
  logic [awvc_pkg::GAP_W-1:0]     acc_gap;
  logic [awvc_pkg::VAR_W-1:0]     acc_var;
  logic [awvc_pkg::TOTAL_W-1:0]   emit_total;

  logic                           block_first;
  logic                           block_end;
  logic                           full_window;
  logic                           has_result;
  logic [CNT_W-1:0]               gather_blocks;
  logic [CNT_W-1:0]               result_count;
  logic [awvc_pkg::GAP_W-1:0]     gap_next;
  logic [awvc_pkg::VAR_W-1:0]     var_next;
  logic [awvc_pkg::TOTAL_W-1:0]   total_next;
  logic                           out_free;

  function automatic logic [SLOT_W-1:0] slot_succ(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_pred(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_LAST : s - SLOT_W'(1);
  endfunction

  assign sum_ready     = (state == ST_IDLE);
  assign block_first   = (off == '0);
  assign block_end     = (off == OFF_LAST);
  assign full_window   = block_end && (seen == BLOCKS_FULL);
  assign has_result    = full_window || sum.last;
  assign gather_blocks = full_window ? BLOCKS_FULL : seen;
  assign result_count  = sum.last ? gather_blocks : CNT_W'(1);
  assign gap_next      = (block_first ? '0 : cur_gap) + awvc_pkg::GAP_W'(sum.gaps);
  assign var_next      = (block_first ? '0 : cur_var) + awvc_pkg::VAR_W'(sum.vars);
  assign total_next    = running_total + awvc_pkg::TOTAL_W'(sum.vars);
  assign out_free      = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      col           <= '0;
      off           <= '0;
      slot          <= '0;
      blk_start     <= '0;
      seen          <= CNT_W'(1);
      running_total <= '0;
      result_valid  <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sum_valid) begin
            cur_gap        <= gap_next;
            cur_var        <= var_next;
            ring_gap[slot] <= gap_next;
            ring_var[slot] <= var_next;
            emit_total     <= total_next;
            rd_slot        <= slot;
            rd_start       <= blk_start;
            cnt            <= gather_blocks;
            rem            <= result_count;
            acc_gap        <= '0;
            acc_var        <= '0;
            if (has_result) begin
              state <= ST_GATHER;
            end
            if (sum.last) begin
              col           <= '0;
              off           <= '0;
              slot          <= '0;
              blk_start     <= '0;
              seen          <= CNT_W'(1);
              running_total <= '0;
            end else begin
              running_total <= total_next;
              col           <= col + CIB'(1);
              if (col == '1) begin
                off       <= '0;
                slot      <= '0;
                blk_start <= '0;
                seen      <= CNT_W'(1);
              end else if (block_end) begin
                off       <= '0;
                slot      <= slot_succ(slot);
                blk_start <= col + CIB'(1);
                seen      <= (seen == BLOCKS_FULL) ? seen : seen + CNT_W'(1);
              end else begin
                off <= off + OFF_W'(1);
              end
            end
          end
        end
        ST_GATHER: begin
          acc_gap <= acc_gap + ring_gap[rd_slot];
          acc_var <= acc_var + ring_var[rd_slot];
          if (cnt == CNT_W'(1)) begin
            state <= ST_EMIT;
          end else begin
            rd_slot  <= slot_pred(rd_slot);
            rd_start <= rd_start - STEP_INC;
            cnt      <= cnt - CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            window_start   <= awvc_pkg::START_W'(rd_start);
            gap_count      <= acc_gap;
            variant_count  <= acc_var;
            total_variants <= emit_total;
            last_of_run    <= (rem == CNT_W'(1));
            acc_gap        <= acc_gap - ring_gap[rd_slot];
            acc_var        <= acc_var - ring_var[rd_slot];
            rd_slot        <= slot_succ(rd_slot);
            rd_start       <= rd_start + STEP_INC;
            rem            <= rem - CNT_W'(1);
            if (rem == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/alignment_window_variation_core.sv
// Top level of the alignment window variation core.
`default_nettype none

// One alignment column is taken per transaction; the front end counts codes in
// one register stage and votes the consensus behind it and can accept a column every
// cycle unless back-pressure holds its stage, while a four-entry queue feeds the
// back end. The back end takes a column that ends no window and is not the final
// column without leaving its idle state. For a column that completes a window, or the
// final column, it reads K (at most WINDOW_BLOCKS) block sums from the ring one per
// cycle, then shows R results, each from an output register that frees as it is
// taken, and takes no new column until the last result is registered. Results of
// one column arrive in ascending window start order, last_of_run marking the last
// one. After reset the block is ready at once; no memory clearing pass is needed.

`include "alignment_window_variation_core_defines.svh"

module alignment_window_variation_core #(
  parameter int NUM_SEQUENCES     = awvc_pkg::NUM_SEQUENCES_DEF,
  parameter int STEP_COLUMNS      = awvc_pkg::STEP_COLUMNS_DEF,
  parameter int WINDOW_BLOCKS     = awvc_pkg::WINDOW_BLOCKS_DEF,
  parameter int COLUMN_INDEX_BITS = awvc_pkg::COLUMN_INDEX_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        column_valid,
  output logic                                             column_ready,
  input  wire logic [awvc_pkg::CODE_W*NUM_SEQUENCES-1:0]   column_bases,
  input  wire logic                                        last_column,
  output logic                                             result_valid,
  input  wire logic                                        result_ready,
  output logic [awvc_pkg::START_W-1:0]                     window_start,
  output logic [awvc_pkg::GAP_W-1:0]                       gap_count,
  output logic [awvc_pkg::VAR_W-1:0]                       variant_count,
  output logic [awvc_pkg::TOTAL_W-1:0]                     total_variants,
  output logic                                             last_of_run
);

  localparam int SUM_W = $bits(awvc_pkg::col_sum_t);

  awvc_pkg::col_sum_t front_sum;
  awvc_pkg::col_sum_t q_sum;
  logic               front_valid;
  logic               front_ready;
  logic               q_valid;
  logic               q_ready;

  awvc_front #(
    .NUM_SEQUENCES (NUM_SEQUENCES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .column_valid (column_valid),
    .column_ready (column_ready),
    .column_bases (column_bases),
    .last_column  (last_column),
    .sum_valid    (front_valid),
    .sum_ready    (front_ready),
    .sum          (front_sum)
  );

  awvc_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (awvc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_sum),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_sum)
  );

  awvc_back #(
    .STEP_COLUMNS      (STEP_COLUMNS),
    .WINDOW_BLOCKS     (WINDOW_BLOCKS),
    .COLUMN_INDEX_BITS (COLUMN_INDEX_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .sum_valid      (q_valid),
    .sum_ready      (q_ready),
    .sum            (q_sum),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .window_start   (window_start),
    .gap_count      (gap_count),
    .variant_count  (variant_count),
    .total_variants (total_variants),
    .last_of_run    (last_of_run)
  );

  `AWVC_ASSERT_NOW(no_pop_mid_run, result_valid && result_ready && !last_of_run, !(q_valid && q_ready), "column taken from queue while a result run is open")
  `AWVC_ASSERT_NEXT(run_continues, result_valid && result_ready && !last_of_run, result_valid, "result run broken before its last transaction")
  `AWVC_ASSERT_NEXT(run_start_step, result_valid && result_ready && !last_of_run, window_start == awvc_pkg::START_W'($past(window_start) + awvc_pkg::START_W'(STEP_COLUMNS)), "window start does not advance by one block")
  `AWVC_ASSERT_NEXT(run_total_stable, result_valid && result_ready && !last_of_run, total_variants == $past(total_variants), "total changed within a result run")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the alignment window variation core, with a column-by-column window predictor.
module testbench;

  localparam int SEQS         = awvc_pkg::NUM_SEQUENCES_DEF;
  localparam int STEP         = awvc_pkg::STEP_COLUMNS_DEF;
  localparam int BLOCKS       = awvc_pkg::WINDOW_BLOCKS_DEF;
  localparam int IDX_W        = awvc_pkg::COLUMN_INDEX_BITS_DEF;
  localparam int COL_W        = awvc_pkg::CODE_W * SEQS;
  localparam int IDLE_PCT     = 36;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 420;
  localparam int LONG_COLUMNS = 1100;

  typedef enum logic [awvc_pkg::CODE_W-1:0] {
    BASE_A, BASE_C, BASE_G, BASE_T, BASE_GAP, BASE_N, BASE_X6, BASE_X7
  } base_code_e;

  typedef struct packed {
    logic [awvc_pkg::START_W-1:0] start;
    logic [awvc_pkg::GAP_W-1:0]   gaps;
    logic [awvc_pkg::VAR_W-1:0]   variants;
    logic [awvc_pkg::TOTAL_W-1:0] total;
    logic                         last;
  } window_report_t;

  logic                         clk;
  logic                         rst;
  logic                         column_valid;
  logic                         column_ready;
  logic [COL_W-1:0]             column_bases;
  logic                         last_column;
  logic                         result_valid;
  logic                         result_ready;
  logic [awvc_pkg::START_W-1:0] window_start;
  logic [awvc_pkg::GAP_W-1:0]   gap_count;
  logic [awvc_pkg::VAR_W-1:0]   variant_count;
  logic [awvc_pkg::TOTAL_W-1:0] total_variants;
  logic                         last_of_run;

  logic [IDX_W-1:0]             next_column;
  int unsigned                  block_gaps [BLOCKS];
  int unsigned                  block_variants [BLOCKS];
  logic [awvc_pkg::TOTAL_W-1:0] alignment_variants;
  window_report_t               expected_reports [$];
  int unsigned                  quiet_cycles;
  int                           errors;
  bit                           steady;

  alignment_window_variation_core dut (
    .clk            (clk),
    .rst            (rst),
    .column_valid   (column_valid),
    .column_ready   (column_ready),
    .column_bases   (column_bases),
    .last_column    (last_column),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .window_start   (window_start),
    .gap_count      (gap_count),
    .variant_count  (variant_count),
    .total_variants (total_variants),
    .last_of_run    (last_of_run)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_alignment();
    next_column = '0;
    alignment_variants = '0;
    foreach (block_gaps[i]) begin
      block_gaps[i] = 0;
      block_variants[i] = 0;
    end
  endfunction

  function automatic void reduce_column(input logic [COL_W-1:0] bases,
                                        output int unsigned gaps,
                                        output int unsigned variants);
    int unsigned tally [awvc_pkg::NUM_CODES];
    int unsigned lead;
    logic [awvc_pkg::CODE_W-1:0] code;
    foreach (tally[k]) tally[k] = 0;
    lead = 0;
    variants = 0;
    for (int j = 0; j < SEQS; j++) begin
      code = bases[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W];
      if (code <= awvc_pkg::CODE_GAP) tally[code]++;
    end
    for (int unsigned k = 1; k < awvc_pkg::NUM_CODES; k++)
      if (tally[k] > tally[lead]) lead = k;
    if (lead != int'(BASE_GAP))
      for (int unsigned k = 0; k < int'(BASE_GAP); k++)
        if (k != lead && tally[k] > 0) variants++;
    gaps = tally[BASE_GAP];
  endfunction

  function automatic window_report_t make_report(input int unsigned start, gaps, variants);
    window_report_t r;
    r.start    = start[awvc_pkg::START_W-1:0];
    r.gaps     = gaps[awvc_pkg::GAP_W-1:0];
    r.variants = variants[awvc_pkg::VAR_W-1:0];
    r.total    = alignment_variants;
    r.last     = 1'b0;
    return r;
  endfunction

  task automatic predict_column(input logic [COL_W-1:0] bases, input logic last);
    int unsigned col, blk, slot, gaps, variants, first, b, sum_g, sum_v;
    window_report_t batch [$];
    col  = next_column;
    blk  = col / STEP;
    slot = blk % BLOCKS;
    if (col % STEP == 0) begin
      block_gaps[slot] = 0;
      block_variants[slot] = 0;
    end
    reduce_column(bases, gaps, variants);
    block_gaps[slot] += gaps;
    block_variants[slot] += variants;
    alignment_variants = alignment_variants + awvc_pkg::TOTAL_W'(variants);
    if (col % STEP == STEP - 1 && col + 1 >= STEP * BLOCKS) begin
      sum_g = 0;
      sum_v = 0;
      foreach (block_gaps[i]) begin
        sum_g += block_gaps[i];
        sum_v += block_variants[i];
      end
      batch.push_back(make_report(col + 1 - STEP * BLOCKS, sum_g, sum_v));
    end
    if (last) begin
      first = (col + 1) / STEP + 1;
      b = (first >= BLOCKS) ? first - BLOCKS : 0;
      for (; b <= blk; b++) begin
        sum_g = 0;
        sum_v = 0;
        for (int unsigned q = b; q <= blk; q++) begin
          sum_g += block_gaps[q % BLOCKS];
          sum_v += block_variants[q % BLOCKS];
        end
        batch.push_back(make_report(b * STEP, sum_g, sum_v));
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_reports.push_back(batch[i]);
    if (last) clear_alignment();
    else next_column = next_column + 1'b1;
  endtask

  function automatic logic [COL_W-1:0] mix_column(input int unsigned n_a, n_c, n_g, n_t,
                                                  n_gap, input base_code_e filler);
    logic [COL_W-1:0] col;
    int unsigned wanted [awvc_pkg::NUM_CODES];
    base_code_e order [awvc_pkg::NUM_CODES];
    int pos;
    wanted = '{n_a, n_c, n_g, n_t, n_gap};
    order = '{BASE_A, BASE_C, BASE_G, BASE_T, BASE_GAP};
    pos = 0;
    for (int j = 0; j < SEQS; j++) col[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] = filler;
    for (int k = 0; k < awvc_pkg::NUM_CODES; k++)
      repeat (wanted[k]) begin
        col[awvc_pkg::CODE_W*pos +: awvc_pkg::CODE_W] = order[k];
        pos++;
      end
    return col;
  endfunction

  function automatic logic [COL_W-1:0] random_column();
    logic [COL_W-1:0] col;
    base_code_e lead;
    int unsigned roll;
    if ($urandom_range(0, 3) == 0) return COL_W'({$urandom(), $urandom()});
    lead = base_code_e'($urandom_range(0, 4));
    for (int j = 0; j < SEQS; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < 82) col[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] = lead;
      else if (roll < 88)
        col[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] = base_code_e'($urandom_range(0, 3));
      else if (roll < 94) col[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] = BASE_GAP;
      else if (roll < 97) col[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] = BASE_N;
      else col[awvc_pkg::CODE_W*j +: awvc_pkg::CODE_W] = base_code_e'($urandom_range(6, 7));
    end
    return col;
  endfunction

  task automatic send_column(input logic [COL_W-1:0] bases, input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      column_valid <= 1'b0;
      @(negedge clk);
    end
    column_valid <= 1'b1;
    column_bases <= bases;
    last_column  <= last;
    @(posedge clk);
    while (!column_ready) @(posedge clk);
    predict_column(bases, last);
  endtask

  task automatic send_alignment(input int unsigned length);
    for (int unsigned j = 0; j < length; j++)
      send_column(random_column(), j == length - 1);
  endtask

  task automatic wait_for_reports();
    @(negedge clk);
    column_valid <= 1'b0;
    while (expected_reports.size() > 0) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  // Close each column on its own to observe its sums, then one short alignment.
  task automatic test_column_codes();
    send_column(mix_column(0, 0, 0, 0, 0, BASE_A), 1'b1);
    send_column(mix_column(0, 0, 0, 0, 0, BASE_X7), 1'b1);
    send_column(mix_column(0, 0, 0, 0, 0, BASE_GAP), 1'b1);
    send_column(mix_column(0, 0, 0, 0, 0, BASE_N), 1'b1);
    send_column(mix_column(0, 0, 0, 0, 0, BASE_X6), 1'b1);
    send_column(mix_column(8, 8, 1, 0, 0, BASE_N), 1'b1);
    send_column(mix_column(0, 8, 0, 1, 8, BASE_N), 1'b1);
    send_column(mix_column(0, 0, 8, 8, 0, BASE_N), 1'b1);
    send_column(mix_column(1, 1, 1, 1, 13, BASE_N), 1'b1);
    send_column(mix_column(1, 1, 1, 14, 0, BASE_N), 1'b1);
    send_column(mix_column(0, 1, 0, 0, 0, BASE_N), 1'b1);
    send_column(mix_column(0, 0, 3, 3, 3, BASE_X6), 1'b1);
    send_column(mix_column(0, 0, 0, 0, 9, BASE_T), 1'b1);
    send_column(mix_column(5, 4, 4, 4, 0, BASE_N), 1'b0);
    send_column(mix_column(2, 3, 2, 2, 2, BASE_X7), 1'b0);
    send_column(mix_column(0, 0, 0, 6, 6, BASE_C), 1'b1);
  endtask

  task automatic test_short_alignments();
    int unsigned sent, length;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       length = $urandom_range(1, 2) * STEP + $urandom_range(0, 2) - 1;
        1:       length = $urandom_range(21, 2 * STEP + 60);
        default: length = $urandom_range(1, 20);
      endcase
      send_alignment(length);
      sent += length;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_for_reports();
        paused = 1;
      end
    end
  endtask

  // Hold both sides busy through the first half of the columns, then idle again.
  task automatic test_full_windows();
    steady = 1;
    for (int unsigned j = 0; j < LONG_COLUMNS; j++) begin
      if (j == LONG_COLUMNS / 2) steady = 0;
      send_column(random_column(), j == LONG_COLUMNS - 1);
    end
  endtask

  always @(negedge clk) result_ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;

  always @(posedge clk) begin : check_reports
    window_report_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result with window_start %0d", window_start);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("window_start", want.start, window_start);
        compare_field("gap_count", want.gaps, gap_count);
        compare_field("variant_count", want.variants, variant_count);
        compare_field("total_variants", want.total, total_variants);
        compare_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (column_valid && column_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    column_valid = 1'b0;
    column_bases = '0;
    last_column = 1'b0;
    result_ready = 1'b0;
    steady = 0;
    errors = 0;
    quiet_cycles = 0;
    clear_alignment();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_column_codes();
    test_short_alignments();
    test_full_windows();
    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
